>>> rtl/qgi_pkg.sv
package qgi_pkg;

   localparam int MAX_Q   = 8;
   localparam int MAX_LEN = 65536;

   localparam int QLEN_W  = 4;
   localparam int VAL_W   = 17;
   localparam int IDX_W   = 17;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int LEN_W   = ADDR_W + 1;
   localparam int RANK_W  = 2 * MAX_Q;
   localparam int CNT_W   = (LEN_W > RANK_W + 1) ? LEN_W : RANK_W + 1;
   localparam int DIR_RAM_DEPTH = 1 << RANK_W;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_QLEN_ADDR = '0;
   localparam logic [QLEN_W-1:0] QLEN_RESET = 4'd4;

   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_DIR  = 2'd1;
   localparam logic [1:0] FUNC_POS  = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_RANGE     = 2'd1;
   localparam logic [1:0] STAT_NOT_BUILT = 2'd2;

   typedef struct packed {
      logic clr;
      logic shift;
      logic back;
   } rank_ctl_type;

   function automatic logic [QLEN_W-1:0] clamp_q(input logic [QLEN_W-1:0] q);
      logic [QLEN_W-1:0] r;
      begin
         r = q;
         if (q == '0) r = QLEN_W'(1);
         if (q > QLEN_W'(MAX_Q)) r = QLEN_W'(MAX_Q);
         return r;
      end
   endfunction

   function automatic logic [RANK_W-1:0] rank_mask(input logic [QLEN_W-1:0] q);
      logic [RANK_W:0] m;
      begin
         m = ((RANK_W+1)'(1) << {q, 1'b0}) - (RANK_W+1)'(1);
         return m[RANK_W-1:0];
      end
   endfunction

   function automatic logic [CNT_W-1:0] dir_lim(input logic [QLEN_W-1:0] q);
      return CNT_W'(1) << {q, 1'b0};
   endfunction

endpackage

>>> rtl/qgi_if.sv
interface qgi_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [1:0] base;
   logic       is_last;
   logic [16:0] index;

   modport source(output valid, func, base, is_last, index, input ready);
   modport sink(input valid, func, base, is_last, index, output ready);
endinterface

interface qgi_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] read_value;
   logic [1:0]  status;
   logic        truncated;

   modport source(output valid, read_value, status, truncated, input ready);
   modport sink(input valid, read_value, status, truncated, output ready);
endinterface

>>> rtl/qgram_direct_address_index_core.sv
// Load word: accepted, no result. Read word: result in the cycle after acceptance for a
// status-only answer or the last directory entry; a table RAM read goes through S_RD_WAIT.
// Build (last base): clear the directory, count the q-grams of the n bases, prefix-sum the
// directory, place positions backward; one shared adder; RAMs with a read and a write port.
// The block takes no word while a build or a read is in progress.
// Reset clears the control state and sets qgram_length to 4; the RAMs are not cleared,
// the directory is cleared by a pass over its 4^q entries at the start of every build.
module qgram_direct_address_index_core import qgi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   qgi_req_if.sink               req_chan,
   qgi_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CLR     = 4'd1;
   localparam logic [3:0] S_CNT_RD  = 4'd2;
   localparam logic [3:0] S_CNT_SH  = 4'd3;
   localparam logic [3:0] S_CNT_WR  = 4'd4;
   localparam logic [3:0] S_PFX_RD  = 4'd5;
   localparam logic [3:0] S_PFX_WR  = 4'd6;
   localparam logic [3:0] S_PLC_RD  = 4'd7;
   localparam logic [3:0] S_PLC_SH  = 4'd8;
   localparam logic [3:0] S_PLC_WR  = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;
   localparam logic [3:0] S_RD_WAIT = 4'd11;

   logic [3:0]        state_ff, state_in;
   logic [QLEN_W-1:0] qlen_ff, qlen_in;
   logic [QLEN_W-1:0] bq_ff, bq_in;
   logic [LEN_W-1:0]  seq_len_ff, seq_len_in;
   logic              built_ff, built_in;
   logic              ovf_ff, ovf_in;
   logic [LEN_W-1:0]  gcount_ff, gcount_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [VAL_W-1:0]  acc_ff, acc_in;
   logic              rd_sel_ff, rd_sel_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_trunc_ff, rsp_trunc_in;

   logic              accept;
   logic [CNT_W-1:0]  lim;
   logic [LEN_W-1:0]  eff_len;
   logic              has_room;
   logic [LEN_W-1:0]  new_len;
   logic [QLEN_W-1:0] q_clamped;
   logic [LEN_W-1:0]  q_ext;
   logic [LEN_W-1:0]  new_gcount;
   logic [CNT_W-1:0]  req_idx;
   logic              cnt_valid;
   logic              plc_valid;

   logic              base_we;
   logic [ADDR_W-1:0] base_waddr, base_raddr;
   logic [1:0]        base_wdata, base_rdata;
   logic              dir_we;
   logic [RANK_W-1:0] dir_waddr, dir_raddr;
   logic [VAL_W-1:0]  dir_wdata, dir_rdata;
   logic              pos_we;
   logic [ADDR_W-1:0] pos_waddr, pos_raddr;
   logic [ADDR_W-1:0] pos_wdata, pos_rdata;

   rank_ctl_type      rank_ctl;
   logic [RANK_W-1:0] rank_nx, rank_q;
   logic [VAL_W-1:0]  alu_a, alu_b, alu_y;
   logic              alu_sub;

   qgi_ram #(.WIDTH(2), .DEPTH(MAX_LEN)) u_base_ram (
      .clock(clock), .we(base_we), .waddr(base_waddr), .wdata(base_wdata),
      .raddr(base_raddr), .rdata(base_rdata)
   );

   qgi_ram #(.WIDTH(VAL_W), .DEPTH(DIR_RAM_DEPTH)) u_dir_ram (
      .clock(clock), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
      .raddr(dir_raddr), .rdata(dir_rdata)
   );

   qgi_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LEN)) u_pos_ram (
      .clock(clock), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
      .raddr(pos_raddr), .rdata(pos_rdata)
   );

   qgi_rank u_rank (
      .clock(clock), .ctl(rank_ctl), .base(base_rdata), .qlen(bq_ff),
      .rank_nx(rank_nx), .rank_q(rank_q)
   );

   qgi_addsub u_addsub (.a(alu_a), .b(alu_b), .sub(alu_sub), .y(alu_y));

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.truncated  = rsp_trunc_ff;

   assign pready = 1'b1;
   assign prdata = CSR_DATA_W'(qlen_ff);

   assign lim        = dir_lim(bq_ff);
   // A load after a finished build starts a new sequence.
   assign eff_len    = built_ff ? '0 : seq_len_ff;
   assign has_room   = (eff_len < LEN_W'(MAX_LEN));
   assign new_len    = has_room ? (eff_len + LEN_W'(1)) : eff_len;
   assign q_clamped  = clamp_q(qlen_ff);
   assign q_ext      = LEN_W'(q_clamped);
   assign new_gcount = (new_len >= q_ext) ? (new_len - q_ext + LEN_W'(1)) : '0;
   assign req_idx    = CNT_W'(req_chan.index);
   assign cnt_valid  = ((CNT_W+1)'(idx_ff) + (CNT_W+1)'(1)) >= (CNT_W+1)'(bq_ff);
   assign plc_valid  = ((CNT_W+1)'(idx_ff) + (CNT_W+1)'(bq_ff)) <= (CNT_W+1)'(seq_len_ff);

   always_comb begin
      state_in      = state_ff;
      qlen_in       = qlen_ff;
      bq_in         = bq_ff;
      seq_len_in    = seq_len_ff;
      built_in      = built_ff;
      ovf_in        = ovf_ff;
      gcount_in     = gcount_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      rd_sel_in     = rd_sel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_trunc_in  = rsp_trunc_ff;

      base_we    = 1'b0;
      base_waddr = eff_len[ADDR_W-1:0];
      base_wdata = req_chan.base;
      base_raddr = idx_ff[ADDR_W-1:0];
      dir_we     = 1'b0;
      dir_waddr  = idx_ff[RANK_W-1:0];
      dir_wdata  = alu_y;
      dir_raddr  = idx_ff[RANK_W-1:0];
      pos_we     = 1'b0;
      pos_waddr  = alu_y[ADDR_W-1:0];
      pos_wdata  = idx_ff[ADDR_W-1:0];
      pos_raddr  = req_chan.index[ADDR_W-1:0];
      rank_ctl   = '0;
      alu_a      = dir_rdata;
      alu_b      = VAL_W'(1);
      alu_sub    = 1'b0;

      if (psel && penable && pwrite && (paddr == CSR_QLEN_ADDR)) begin
         qlen_in = pwdata[QLEN_W-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_chan.func)
                  FUNC_LOAD: begin
                     built_in   = 1'b0;
                     seq_len_in = new_len;
                     ovf_in     = (ovf_ff && !built_ff) || !has_room;
                     base_we    = has_room;
                     if (req_chan.is_last) begin
                        bq_in     = q_clamped;
                        gcount_in = new_gcount;
                        idx_in    = '0;
                        state_in  = S_CLR;
                     end
                  end
                  FUNC_DIR: begin
                     rsp_trunc_in = ovf_ff;
                     if (!built_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_status_in = STAT_NOT_BUILT;
                     end else if (req_idx == lim) begin
                        // The last directory entry is the total q-gram count.
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = VAL_W'(gcount_ff);
                        rsp_status_in = STAT_OK;
                     end else if (req_idx < lim) begin
                        dir_raddr = req_chan.index[RANK_W-1:0];
                        rd_sel_in = 1'b0;
                        state_in  = S_RD_WAIT;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_status_in = STAT_RANGE;
                     end
                  end
                  FUNC_POS: begin
                     rsp_trunc_in = ovf_ff;
                     if (!built_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_status_in = STAT_NOT_BUILT;
                     end else if (req_idx < CNT_W'(gcount_ff)) begin
                        rd_sel_in = 1'b1;
                        state_in  = S_RD_WAIT;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_status_in = STAT_RANGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CLR: begin
            dir_we    = 1'b1;
            dir_wdata = '0;
            if (idx_ff == lim - CNT_W'(1)) begin
               idx_in       = '0;
               rank_ctl.clr = 1'b1;
               state_in     = S_CNT_RD;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_CNT_RD: begin
            if (idx_ff == CNT_W'(seq_len_ff)) begin
               idx_in   = '0;
               acc_in   = '0;
               state_in = S_PFX_RD;
            end else begin
               state_in = S_CNT_SH;
            end
         end
         S_CNT_SH: begin
            rank_ctl.shift = 1'b1;
            dir_raddr      = rank_nx;
            if (cnt_valid) begin
               state_in = S_CNT_WR;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_CNT_RD;
            end
         end
         S_CNT_WR: begin
            dir_we    = 1'b1;
            dir_waddr = rank_q;
            idx_in    = idx_ff + CNT_W'(1);
            state_in  = S_CNT_RD;
         end
         S_PFX_RD: begin
            if (idx_ff == lim) begin
               idx_in       = CNT_W'(seq_len_ff) - CNT_W'(1);
               rank_ctl.clr = 1'b1;
               state_in     = S_PLC_RD;
            end else begin
               state_in = S_PFX_WR;
            end
         end
         S_PFX_WR: begin
            alu_a    = acc_ff;
            alu_b    = dir_rdata;
            dir_we   = 1'b1;
            acc_in   = alu_y;
            idx_in   = idx_ff + CNT_W'(1);
            state_in = S_PFX_RD;
         end
         S_PLC_RD: begin
            state_in = S_PLC_SH;
         end
         S_PLC_SH: begin
            // Walking the bases backward keeps positions ascending within a rank.
            rank_ctl.shift = 1'b1;
            rank_ctl.back  = 1'b1;
            dir_raddr      = rank_nx;
            if (plc_valid) begin
               state_in = S_PLC_WR;
            end else if (idx_ff == '0) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff - CNT_W'(1);
               state_in = S_PLC_RD;
            end
         end
         S_PLC_WR: begin
            alu_sub   = 1'b1;
            dir_we    = 1'b1;
            dir_waddr = rank_q;
            pos_we    = 1'b1;
            if (idx_ff == '0) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff - CNT_W'(1);
               state_in = S_PLC_RD;
            end
         end
         S_DONE: begin
            built_in      = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_value_in  = VAL_W'(gcount_ff);
            rsp_status_in = STAT_OK;
            rsp_trunc_in  = ovf_ff;
            state_in      = S_IDLE;
         end
         S_RD_WAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = rd_sel_ff ? VAL_W'(pos_rdata) : dir_rdata;
            rsp_status_in = STAT_OK;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         qlen_ff      <= QLEN_RESET;
         bq_ff        <= QLEN_W'(1);
         seq_len_ff   <= '0;
         built_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         gcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         qlen_ff      <= qlen_in;
         bq_ff        <= bq_in;
         seq_len_ff   <= seq_len_in;
         built_ff     <= built_in;
         ovf_ff       <= ovf_in;
         gcount_ff    <= gcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      acc_ff        <= acc_in;
      rd_sel_ff     <= rd_sel_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_trunc_ff  <= rsp_trunc_in;
   end

`ifndef ASSERT_OFF
   a_prefix_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PFX_RD && idx_ff == lim) |-> acc_ff == VAL_W'(gcount_ff))
      else $error("prefix total differs from q-gram count");

   a_gcount_bound: assert property (@(posedge clock) disable iff (reset)
      built_ff |-> gcount_ff <= seq_len_ff)
      else $error("q-gram count exceeds sequence length");

   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CNT_WR || state_ff == S_PLC_WR) |-> CNT_W'(rank_q) < lim)
      else $error("rank outside directory");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_IDLE || $past(state_ff) == S_DONE
                              || $past(state_ff) == S_RD_WAIT))
      else $error("result word raised from a build step");

   a_built_len: assert property (@(posedge clock) disable iff (reset)
      built_ff |-> seq_len_ff != '0)
      else $error("index built over an empty sequence");
`endif

endmodule

>>> rtl/qgi_ram.sv
module qgi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> rtl/qgi_addsub.sv
module qgi_addsub import qgi_pkg::*; (
   input  logic [VAL_W-1:0] a,
   input  logic [VAL_W-1:0] b,
   input  logic             sub,
   output logic [VAL_W-1:0] y
);

   assign y = sub ? (a - b) : (a + b);

endmodule

>>> rtl/qgi_rank.sv
module qgi_rank import qgi_pkg::*; (
   input  logic              clock,
   input  rank_ctl_type      ctl,
   input  logic [1:0]        base,
   input  logic [QLEN_W-1:0] qlen,
   output logic [RANK_W-1:0] rank_nx,
   output logic [RANK_W-1:0] rank_q
);

   logic [RANK_W-1:0] rank_ff;
   logic [RANK_W-1:0] rank_in;
   logic [QLEN_W:0]   top_shamt;

   // In the backward direction the new base becomes the most significant digit.
   assign top_shamt = {qlen - QLEN_W'(1), 1'b0};

   always_comb begin
      rank_in = rank_ff;
      if (ctl.clr) begin
         rank_in = '0;
      end else if (ctl.shift) begin
         if (ctl.back) begin
            rank_in = (rank_ff >> 2) | (RANK_W'(base) << top_shamt);
         end else begin
            rank_in = {rank_ff[RANK_W-3:0], base} & rank_mask(qlen);
         end
      end
   end

   always_ff @(posedge clock) begin
      rank_ff <= rank_in;
   end

   assign rank_nx = rank_in;
   assign rank_q  = rank_ff;

endmodule

>>> tb/qgram_index_checker.sv
module qgram_index_checker import qgi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   qgi_req_if                    req_mon,
   qgi_rsp_if                    rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int unsigned           answers_due,
   output int unsigned           mismatch_count
);

   localparam int DIR_SIZE = (1 << (2 * MAX_Q)) + 1;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [1:0]       status;
      logic             truncated;
   } answer_type;

   answer_type              answer_q[$];
   logic [1:0]              base_mem[MAX_LEN];
   logic [VAL_W-1:0]        dir_mem[DIR_SIZE];
   logic [ADDR_W-1:0]       pos_mem[MAX_LEN];
   int unsigned             seq_len;
   int unsigned             built_q;
   int unsigned             gram_total;
   bit                      built;
   bit                      overflowed;
   logic [QLEN_W-1:0]       qlen;

   initial begin
      mismatch_count = 0;
      answers_due    = 0;
   end

   function automatic int unsigned gram_rank(input int unsigned start, input int unsigned q);
      int unsigned r;
      int unsigned k;
      r = 0;
      for (k = 0; k < q; k++) begin
         r = (r << 2) | base_mem[start + k];
      end
      return r;
   endfunction

   function automatic answer_type make_answer(input logic [VAL_W-1:0] value,
                                              input logic [1:0] status);
      answer_type a;
      a.value     = value;
      a.status    = status;
      a.truncated = overflowed;
      return a;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   always @(posedge clock) begin
      answer_type  got;
      answer_type  want;
      int unsigned q;
      int unsigned dsize;
      int unsigned r;
      int unsigned i;
      if (reset) begin
         answer_q.delete();
         seq_len    = 0;
         built_q    = 1;
         gram_total = 0;
         built      = 1'b0;
         overflowed = 1'b0;
         qlen       = QLEN_RESET;
      end else begin
         if (psel && penable && pwrite && pready && paddr == CSR_QLEN_ADDR) begin
            qlen = pwdata[QLEN_W-1:0];
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.func)
               FUNC_LOAD: begin
                  // The first base after a build opens a new sequence.
                  if (built) begin
                     built      = 1'b0;
                     seq_len    = 0;
                     overflowed = 1'b0;
                  end
                  if (seq_len < MAX_LEN) begin
                     base_mem[seq_len] = req_mon.base;
                     seq_len++;
                  end else begin
                     overflowed = 1'b1;
                  end
                  if (req_mon.is_last) begin
                     q = qlen;
                     if (q < 1) q = 1;
                     if (q > MAX_Q) q = MAX_Q;
                     dsize      = (1 << (2 * q)) + 1;
                     built_q    = q;
                     gram_total = (seq_len >= q) ? seq_len - q + 1 : 0;
                     for (i = 0; i < dsize; i++) dir_mem[i] = '0;
                     for (i = 0; i < gram_total; i++) begin
                        r = gram_rank(i, q);
                        dir_mem[r]++;
                     end
                     for (i = 1; i < dsize; i++) dir_mem[i] += dir_mem[i - 1];
                     // Scatter from the back so each rank keeps ascending positions.
                     for (i = gram_total; i > 0; i--) begin
                        r = gram_rank(i - 1, q);
                        dir_mem[r]--;
                        pos_mem[dir_mem[r]] = ADDR_W'(i - 1);
                     end
                     built = 1'b1;
                     answer_q.push_back(make_answer(VAL_W'(gram_total), STAT_OK));
                  end
               end
               FUNC_DIR: begin
                  if (!built) begin
                     answer_q.push_back(make_answer('0, STAT_NOT_BUILT));
                  end else if (req_mon.index < (1 << (2 * built_q)) + 1) begin
                     answer_q.push_back(make_answer(dir_mem[req_mon.index], STAT_OK));
                  end else begin
                     answer_q.push_back(make_answer('0, STAT_RANGE));
                  end
               end
               FUNC_POS: begin
                  if (!built) begin
                     answer_q.push_back(make_answer('0, STAT_NOT_BUILT));
                  end else if (req_mon.index < gram_total) begin
                     answer_q.push_back(make_answer(VAL_W'(pos_mem[req_mon.index]), STAT_OK));
                  end else begin
                     answer_q.push_back(make_answer('0, STAT_RANGE));
                  end
               end
               default: begin
               end
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.value     = rsp_mon.read_value;
            got.status    = rsp_mon.status;
            got.truncated = rsp_mon.truncated;
            if (answer_q.size() == 0) begin
               report_mismatch($sformatf("result word with nothing expected (value %0d)",
                                         got.value));
            end else begin
               want = answer_q.pop_front();
               if (got.value !== want.value)
                  report_mismatch($sformatf("read_value %0d, expected %0d",
                                            got.value, want.value));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, want.status));
               if (got.truncated !== want.truncated)
                  report_mismatch($sformatf("truncated %0b, expected %0b",
                                            got.truncated, want.truncated));
            end
         end
      end
      answers_due = answer_q.size();
   end

endmodule

>>> tb/qgram_direct_address_index_core_tb.sv
module qgram_direct_address_index_core_tb import qgi_pkg::*; ();

   localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
   localparam int unsigned CYCLE_LIMIT  = 8_000_000;
   localparam int unsigned RANDOM_WORDS = 1850;
   localparam int unsigned IDX_MAX      = (1 << IDX_W) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qgi_req_if req_chan();
   qgi_rsp_if rsp_chan();

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int unsigned fail_total;
   int unsigned answers_due;
   int unsigned cycle_count = 0;
   int unsigned words_sent  = 0;
   bit          calm        = 1'b0;

   // Coarse view of the current sequence, used only to aim the reads.
   int unsigned eff_q       = 4;
   int unsigned seq_bases   = 0;
   bit          seq_closed  = 1'b1;
   int unsigned table_size  = 1;
   int unsigned gram_count  = 0;

   always #10 clock = ~clock;

   qgram_direct_address_index_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   qgram_index_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .answers_due    (answers_due),
      .mismatch_count (fail_total)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("qgram_direct_address_index_core verification failed");
         $finish;
      end
   end

   initial rsp_chan.ready = 1'b0;
   always @(negedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(99) >= 15);
   end

   task automatic send_word(input logic [1:0] func, input logic [1:0] base,
                            input logic last, input logic [IDX_W-1:0] idx);
      while (!calm && $urandom_range(99) < 15) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.func    <= func;
      req_chan.base    <= base;
      req_chan.is_last <= last;
      req_chan.index   <= idx;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (func != FUNC_UNUSED) words_sent++;
      if (func == FUNC_LOAD) begin
         if (seq_closed) begin
            seq_bases  = 0;
            seq_closed = 1'b0;
         end
         if (seq_bases < MAX_LEN) seq_bases++;
         if (last) begin
            gram_count = (seq_bases >= eff_q) ? seq_bases - eff_q + 1 : 0;
            table_size = (1 << (2 * eff_q)) + 1;
            seq_closed = 1'b1;
         end
      end
   endtask

   task automatic load_base(input logic [1:0] base, input logic last);
      send_word(FUNC_LOAD, base, last, IDX_W'($urandom_range(0, IDX_MAX)));
   endtask

   task automatic read_entry(input logic [1:0] func, input int unsigned idx);
      send_word(func, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), IDX_W'(idx));
   endtask

   // Drop valid and wait until every expected word has come back and the block is quiet.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (answers_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_qlen(input logic [QLEN_W-1:0] value);
      logic [CSR_DATA_W-1:0] wdata;
      settle();
      wdata               = $urandom;
      wdata[QLEN_W-1:0]   = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_QLEN_ADDR;
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      eff_q = (value == 0) ? 1 : (value > MAX_Q) ? MAX_Q : value;
   endtask

   task automatic load_sequence(input int unsigned len, input bit noisy);
      int unsigned k;
      for (k = 0; k < len; k++) begin
         if (noisy && $urandom_range(99) < 10) begin
            if ($urandom_range(1))
               send_word(FUNC_UNUSED, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         IDX_W'($urandom_range(0, IDX_MAX)));
            else
               read_entry($urandom_range(0, 1) ? FUNC_DIR : FUNC_POS,
                          $urandom_range(0, 300));
         end
         load_base(2'($urandom_range(0, 3)), k == len - 1);
      end
   endtask

   task automatic read_tables(input int unsigned count);
      int unsigned n;
      int unsigned r;
      int unsigned idx;
      for (n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if ($urandom_range(1)) begin
            if (r < 80) idx = $urandom_range(0, table_size - 1);
            else if (r < 90) idx = table_size + $urandom_range(0, 3);
            else idx = $urandom_range(0, IDX_MAX);
            read_entry(FUNC_DIR, idx);
         end else begin
            if (r < 80 && gram_count > 0) idx = $urandom_range(0, gram_count - 1);
            else if (r < 90) idx = gram_count + $urandom_range(0, 3);
            else idx = $urandom_range(0, IDX_MAX);
            read_entry(FUNC_POS, idx);
         end
      end
   endtask

   initial begin
      int unsigned start_words;
      int unsigned len;
      int unsigned r;
      req_chan.valid   = 1'b0;
      req_chan.func    = FUNC_LOAD;
      req_chan.base    = 2'd0;
      req_chan.is_last = 1'b0;
      req_chan.index   = '0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = CSR_QLEN_ADDR;
      pwdata  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Nothing built yet, and an unused function code that must be ignored.
      read_entry(FUNC_DIR, 0);
      read_entry(FUNC_POS, IDX_MAX);
      send_word(FUNC_UNUSED, 2'd3, 1'b1, IDX_W'(IDX_MAX));

      // Reset length of four against a three-base sequence: no grams at all.
      load_base(2'd0, 1'b0);
      load_base(2'd1, 1'b0);
      load_base(2'd3, 1'b1);
      read_entry(FUNC_DIR, 0);
      read_entry(FUNC_DIR, 256);
      read_entry(FUNC_DIR, 257);
      read_entry(FUNC_POS, 0);

      // A length of zero behaves as one.
      write_qlen(4'd0);
      load_base(2'd0, 1'b0);
      load_base(2'd1, 1'b0);
      load_base(2'd2, 1'b0);
      load_base(2'd3, 1'b0);
      load_base(2'd3, 1'b0);
      load_base(2'd0, 1'b1);
      read_entry(FUNC_DIR, 1);
      read_entry(FUNC_DIR, 4);
      read_entry(FUNC_POS, 5);
      read_entry(FUNC_POS, 6);

      // A new base after a build discards the old index.
      load_base(2'd2, 1'b0);
      read_entry(FUNC_POS, 0);
      load_base(2'd2, 1'b1);

      // Lengths above the maximum behave as the maximum.
      write_qlen(4'd15);
      load_sequence(10, 1'b0);
      read_entry(FUNC_DIR, 1 << (2 * MAX_Q));
      read_entry(FUNC_DIR, (1 << (2 * MAX_Q)) + 1);
      read_entry(FUNC_DIR, IDX_MAX);

      // The largest length over a sequence that holds several q-grams.
      write_qlen(4'(MAX_Q));
      load_sequence(40, 1'b0);
      read_entry(FUNC_DIR, 1 << (2 * MAX_Q));
      read_entry(FUNC_POS, gram_count - 1);
      read_entry(FUNC_POS, gram_count);
      read_tables(8);

      start_words = words_sent;
      while (words_sent - start_words < RANDOM_WORDS) begin
         calm = (words_sent - start_words >= 900) && (words_sent - start_words < 1200);
         if ($urandom_range(3) == 0) begin
            r = $urandom_range(99);
            write_qlen(r < 8 ? 4'd0 : r < 95 ? 4'($urandom_range(1, 5)) : 4'd6);
         end
         r = $urandom_range(99);
         if (r < 70) len = $urandom_range(1, 24);
         else if (r < 85) len = $urandom_range(25, 120);
         else len = (eff_q > 1) ? $urandom_range(1, eff_q - 1) : 1;
         load_sequence(len, 1'b1);
         // The read side must keep using the length of the finished build.
         if ($urandom_range(9) == 0) write_qlen(4'($urandom_range(0, 6)));
         read_tables($urandom_range(2, 12));
         if ($urandom_range(7) == 0) settle();
         if ($urandom_range(9) == 0)
            send_word(FUNC_UNUSED, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      IDX_W'($urandom_range(0, IDX_MAX)));
      end
      calm = 1'b0;

      settle();
      repeat (12) @(negedge clock);
      if (fail_total == 0) begin
         $display("qgram_direct_address_index_core verification clean");
      end else begin
         $display("qgram_direct_address_index_core verification failed");
      end
      $finish;
   end

endmodule
